### rtl/twsr_pkg.sv
package twsr_pkg;

	localparam int COORD_BITS = 24;
	localparam int WIN_BITS   = 13;
	localparam int TEX_BITS   = 7;
	localparam int MAX_WINDOW = 4096;
	// dividends stay well under 2^30 in magnitude
	localparam int DIV_BITS   = 32;

	localparam logic [1:0] REG_WINDOW   = 2'd0;
	localparam logic [1:0] REG_TEXEL    = 2'd1;
	localparam logic [1:0] REG_ORIGIN_X = 2'd2;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BX_DIV,
		ST_BX_MOD,
		ST_BY_DIV,
		ST_BY_MOD,
		ST_RECT,
		ST_WX,
		ST_WY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                start;
		logic                is_mod;
		logic signed [DIV_BITS-1:0] dividend;
		logic [WIN_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic signed [DIV_BITS-1:0] result;
	} div_rsp_t;

endpackage

### rtl/twsr_div.sv
// Restoring divider, one quotient bit per cycle. Quotient truncates toward zero;
// mod mode returns floored remainder (divisor positive).
module twsr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  twsr_pkg::div_req_t req,
	output twsr_pkg::div_rsp_t rsp
);
	localparam int N = twsr_pkg::DIV_BITS;

	logic [N-1:0]  quo_q;
	logic [N-1:0]  rem_q;
	logic [twsr_pkg::WIN_BITS-1:0] dvs_q;
	logic          neg_q, mod_q, busy_q, done_q;
	logic [5:0]    cnt_q;
	logic [N-1:0]  mag;
	logic [N:0]    trial;
	logic [N-1:0]  rem_shift;
	logic [N-1:0]  fix_rem;

	assign mag       = req.dividend[N-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign rem_shift = {rem_q[N-2:0], quo_q[N-1]};
	assign trial     = {1'b0, rem_shift} - {{(N+1-twsr_pkg::WIN_BITS){1'b0}}, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= req.divisor;
			neg_q <= req.dividend[N-1];
			mod_q <= req.is_mod;
		end else if (busy_q) begin
			if (!trial[N]) begin
				rem_q <= trial[N-1:0];
				quo_q <= {quo_q[N-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift;
				quo_q <= {quo_q[N-2:0], 1'b0};
			end
		end
	end

	assign fix_rem = (neg_q && rem_q != '0)
		? ({{(N-twsr_pkg::WIN_BITS){1'b0}}, dvs_q} - rem_q) : rem_q;

	always_comb begin
		rsp.done = done_q;
		if (mod_q)
			rsp.result = fix_rem;
		else
			rsp.result = neg_q ? (~quo_q + 1'b1) : quo_q;
	end
endmodule

### rtl/toroidal_window_scroll_regions.sv
// Toroidal window scroll regions.
// Input channel: move_x/move_y beats under in_valid/in_stall. Each nonzero
// move emits one rectangle (straight move or full reload) or three (diagonal:
// strip, corner square, second strip; last marks the final one) on the output
// channel out_valid/out_stall. A zero move produces nothing.
// Config channel: cfg_valid/cfg_ready, cfg_index/cfg_data; 0 window_texels,
// 1 texel_size, 2 origin_x, 3 origin_y. Written only while idle with no move
// offered, so a move never sees a setting change under it.
// Sequencing: one shared 32-step restoring divider does four divisions for the
// toroidal base (trunc divide by texel_size, floored mod by window, each axis),
// then two floored mods per rectangle for wrap_start. in_stall stays high from
// accept until the last rectangle is taken. An output stall simply holds the
// presented rectangle.
// Reset: window 256, texel 1, origins, bases and toroidal bases cleared.
module toroidal_window_scroll_regions (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] move_x,
	input  logic signed [23:0] move_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         rect_index,
	output logic signed [23:0] start_x,
	output logic signed [23:0] start_y,
	output logic signed [23:0] end_x,
	output logic signed [23:0] end_y,
	output logic [11:0]        wrap_start_x,
	output logic [11:0]        wrap_start_y,
	output logic [17:0]        wrap_base_x,
	output logic [17:0]        wrap_base_y,
	output logic               full_reload,
	output logic               last
);
	localparam int C = twsr_pkg::COORD_BITS;
	localparam int N = twsr_pkg::DIV_BITS;

	twsr_pkg::state_t state_q, state_d;

	logic [12:0] win_q;
	logic [6:0]  tex_q;
	logic signed [23:0] org_x_q, org_y_q;
	logic signed [C-1:0] base_x_q, base_y_q;
	logic [17:0] wb_x_q, wb_y_q;

	// per-move working registers
	logic signed [26:0] ox_q, oy_q, nx_q, ny_q, dx_q, dy_q;
	logic signed [N-1:0] tmp_q;
	logic [17:0] nwb_x_q, nwb_y_q;
	logic        full_q, diag_q;
	logic [1:0]  rect_q;
	logic signed [26:0] sx_q, sy_q, ex_q, ey_q;
	logic        start_pend_q;
	logic [11:0] wsx_q, wsy_q;

	logic [12:0] w_eff;
	logic [6:0]  t_eff;
	logic [19:0] ww;
	logic signed [26:0] wws;
	logic        in_acc, out_acc;

	twsr_pkg::div_req_t dreq;
	twsr_pkg::div_rsp_t drsp;

	twsr_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign w_eff = (win_q == '0) ? 13'd1 : (win_q > 13'(twsr_pkg::MAX_WINDOW))
		? 13'(twsr_pkg::MAX_WINDOW) : win_q;
	assign t_eff = (tex_q == '0) ? 7'd1 : tex_q;
	assign ww    = w_eff * t_eff;
	assign wws   = 27'(ww);

	assign in_stall  = (state_q != twsr_pkg::ST_IDLE);
	assign cfg_ready = (state_q == twsr_pkg::ST_IDLE) && !in_valid;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == twsr_pkg::ST_OUT);
	assign out_acc   = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= 13'd256;
			tex_q   <= 7'd1;
			org_x_q <= '0;
			org_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				twsr_pkg::REG_WINDOW:   win_q   <= cfg_data[12:0];
				twsr_pkg::REG_TEXEL:    tex_q   <= cfg_data[6:0];
				twsr_pkg::REG_ORIGIN_X: org_x_q <= cfg_data;
				twsr_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// rectangle geometry for the current rect_q, per sign case
	logic signed [26:0] g_sx, g_sy, g_ex, g_ey;
	logic px, nxs, py, nys;
	always_comb begin
		px  = dx_q > 0;  nxs = dx_q < 0;
		py  = dy_q > 0;  nys = dy_q < 0;
		g_sx = nx_q; g_sy = ny_q; g_ex = nx_q + wws; g_ey = ny_q + wws;
		if (rect_q == 2'd0) begin
			if (!full_q) begin
				if (px && !py && !nys) g_sx = ox_q + wws;
				else if (px && py) begin g_sx = ox_q + wws; g_ey = oy_q + wws; end
				else if (!px && !nxs && py) g_sy = oy_q + wws;
				else if (nxs && py) begin g_ex = ox_q; g_ey = oy_q + wws; end
				else if (nxs && !py && !nys) g_ex = ox_q;
				else if (nxs && nys) begin g_sx = ox_q; g_ey = oy_q; end
				else if (!px && !nxs && nys) g_ey = oy_q;
				else begin g_ey = oy_q; g_ex = ox_q + wws; end
			end
		end else if (rect_q == 2'd1) begin
			g_ex = ox_q; g_ey = oy_q;
			if (px && py) begin
				g_sx = ox_q + wws; g_sy = oy_q + wws; g_ex = nx_q + wws; g_ey = ny_q + wws;
			end else if (px && nys) begin
				g_sx = ox_q + wws; g_ex = ox_q + wws;
			end else if (nxs && py) begin
				g_sy = oy_q + wws; g_ey = ny_q + wws;
			end
		end else begin
			g_ex = ox_q; g_ey = oy_q;
			if (px && py) begin
				g_sy = oy_q + wws; g_ex = ox_q + wws; g_ey = ny_q + wws;
			end else if (px && nys) begin
				g_sx = ox_q + wws; g_ex = nx_q + wws; g_ey = ny_q + wws;
			end else if (nxs && py) begin
				g_sy = oy_q + wws; g_ex = nx_q + wws; g_ey = ny_q + wws;
			end else begin
				g_sy = oy_q; g_ey = ny_q + wws;
			end
		end
	end

	logic signed [26:0] nbx, nby;
	logic signed [C-1:0] nbx_w, nby_w;
	logic [17:0] tprod;
	assign nbx_w = C'(ox_q + dx_q);
	assign nby_w = C'(oy_q + dy_q);
	assign nbx   = 27'(nbx_w);
	assign nby   = 27'(nby_w);
	assign tprod = 18'(drsp.result[12:0] * t_eff);

	logic wfull;
	assign wfull = (move_x > $signed({4'd0, ww})) || (-27'(move_x) > wws)
		|| (move_y > $signed({4'd0, ww})) || (-27'(move_y) > wws);

	always_comb begin
		state_d = state_q;
		dreq.start = 1'b0; dreq.is_mod = 1'b0; dreq.dividend = '0;
		dreq.divisor = {6'd0, t_eff};
		unique case (state_q)
			twsr_pkg::ST_IDLE: if (in_acc && (move_x != 0 || move_y != 0))
				state_d = twsr_pkg::ST_BX_DIV;
			twsr_pkg::ST_BX_DIV, twsr_pkg::ST_BY_DIV, twsr_pkg::ST_BX_MOD,
			twsr_pkg::ST_BY_MOD, twsr_pkg::ST_WX, twsr_pkg::ST_WY: ;
			twsr_pkg::ST_RECT: ;
			twsr_pkg::ST_OUT: ;
			default: state_d = twsr_pkg::ST_IDLE;
		endcase
		// sequencer launches a division on entry (start_pend_q marks pending)
		if (start_pend_q) begin
			dreq.start = 1'b1;
			unique case (state_q)
				twsr_pkg::ST_BX_DIV: dreq.dividend = N'(nbx) - N'(org_x_q);
				twsr_pkg::ST_BY_DIV: dreq.dividend = N'(nby) - N'(org_y_q);
				twsr_pkg::ST_BX_MOD, twsr_pkg::ST_BY_MOD: begin
					dreq.dividend = tmp_q; dreq.is_mod = 1'b1; dreq.divisor = w_eff;
				end
				twsr_pkg::ST_WX: begin
					dreq.dividend = N'(sx_q) - N'(org_x_q); dreq.is_mod = 1'b1;
					dreq.divisor = w_eff;
				end
				twsr_pkg::ST_WY: begin
					dreq.dividend = N'(sy_q) - N'(org_y_q); dreq.is_mod = 1'b1;
					dreq.divisor = w_eff;
				end
				default: dreq.start = 1'b0;
			endcase
		end
		if (drsp.done) begin
			unique case (state_q)
				twsr_pkg::ST_BX_DIV: state_d = twsr_pkg::ST_BX_MOD;
				twsr_pkg::ST_BX_MOD: state_d = twsr_pkg::ST_BY_DIV;
				twsr_pkg::ST_BY_DIV: state_d = twsr_pkg::ST_BY_MOD;
				twsr_pkg::ST_BY_MOD: state_d = twsr_pkg::ST_RECT;
				twsr_pkg::ST_WX:     state_d = twsr_pkg::ST_WY;
				twsr_pkg::ST_WY:     state_d = twsr_pkg::ST_OUT;
				default: ;
			endcase
		end
		if (state_q == twsr_pkg::ST_RECT) state_d = twsr_pkg::ST_WX;
		if (out_acc) state_d = last ? twsr_pkg::ST_IDLE : twsr_pkg::ST_RECT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= twsr_pkg::ST_IDLE;
			start_pend_q <= 1'b0;
			base_x_q <= '0; base_y_q <= '0; wb_x_q <= '0; wb_y_q <= '0;
		end else begin
			state_q      <= state_d;
			start_pend_q <= (state_d != state_q) && (state_d != twsr_pkg::ST_RECT)
				&& (state_d != twsr_pkg::ST_OUT) && (state_d != twsr_pkg::ST_IDLE);
			if (out_acc && last) begin
				base_x_q <= nbx_w; base_y_q <= nby_w;
				wb_x_q <= nwb_x_q; wb_y_q <= nwb_y_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ox_q <= 27'(base_x_q); oy_q <= 27'(base_y_q);
			dx_q <= 27'(move_x);   dy_q <= 27'(move_y);
			nx_q <= 27'(base_x_q) + 27'(move_x);
			ny_q <= 27'(base_y_q) + 27'(move_y);
			full_q <= wfull;
			diag_q <= !wfull && move_x != 0 && move_y != 0;
			rect_q <= 2'd0;
		end
		if (drsp.done) begin
			unique case (state_q)
				twsr_pkg::ST_BX_DIV, twsr_pkg::ST_BY_DIV: tmp_q <= drsp.result;
				twsr_pkg::ST_BX_MOD: nwb_x_q <= tprod;
				twsr_pkg::ST_BY_MOD: nwb_y_q <= tprod;
				twsr_pkg::ST_WX:     wsx_q   <= drsp.result[11:0];
				twsr_pkg::ST_WY:     wsy_q   <= drsp.result[11:0];
				default: ;
			endcase
		end
		if (state_q == twsr_pkg::ST_RECT) begin
			sx_q <= g_sx; sy_q <= g_sy; ex_q <= g_ex; ey_q <= g_ey;
		end
		if (out_acc && !last) rect_q <= rect_q + 2'd1;
	end

	assign rect_index   = rect_q;
	assign start_x      = sx_q[23:0];
	assign start_y      = sy_q[23:0];
	assign end_x        = ex_q[23:0];
	assign end_y        = ey_q[23:0];
	assign wrap_start_x = wsx_q;
	assign wrap_start_y = wsy_q;
	assign wrap_base_x  = nwb_x_q;
	assign wrap_base_y  = nwb_y_q;
	assign full_reload  = full_q;
	assign last         = !diag_q || (rect_q == 2'd2);

	// no new move while a move is in flight
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while busy");
	// rectangles after the first never carry full_reload
	a_diag_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rect_index != 2'd0) |-> !full_reload)
		else $error("multi-rect with reload");
	// a completed last beat returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !in_stall) else $error("stuck after last");
endmodule

### tb/twsr_scoreboard.sv
`timescale 1ns / 1ps

module twsr_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [23:0] move_x,
	input  logic signed [23:0] move_y,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         rect_index,
	input  logic signed [23:0] start_x,
	input  logic signed [23:0] start_y,
	input  logic signed [23:0] end_x,
	input  logic signed [23:0] end_y,
	input  logic [11:0]        wrap_start_x,
	input  logic [11:0]        wrap_start_y,
	input  logic [17:0]        wrap_base_x,
	input  logic [17:0]        wrap_base_y,
	input  logic               full_reload,
	input  logic               last,
	output int                 fail_count,
	output int                 rects_pending
);
	typedef struct {
		logic [1:0]  idx;
		logic [23:0] sx, sy, ex, ey;
		logic [11:0] wsx, wsy;
		logic [17:0] wbx, wby;
		logic        full, fin;
	} rect_t;

	rect_t rect_q[$];

	logic [12:0]        win_texels;
	logic [6:0]         tex_size;
	logic signed [23:0] org_x, org_y;
	logic signed [23:0] base_x, base_y;

	function automatic longint fmod(longint a, longint m);
		longint r;
		r = a % m;
		if (r < 0)
			r += m;
		return r;
	endfunction

	task automatic push_rect(input int idx, input longint sx, input longint sy,
			input longint ex, input longint ey, input longint w,
			input logic [17:0] wbx, input logic [17:0] wby, input bit full, input bit fin);
		rect_t r;
		r.idx  = idx[1:0];
		r.sx   = sx[23:0];
		r.sy   = sy[23:0];
		r.ex   = ex[23:0];
		r.ey   = ey[23:0];
		r.wsx  = 12'(fmod(sx - longint'(org_x), w));
		r.wsy  = 12'(fmod(sy - longint'(org_y), w));
		r.wbx  = wbx;
		r.wby  = wby;
		r.full = full;
		r.fin  = fin;
		rect_q.push_back(r);
	endtask

	task automatic predict_move(input logic signed [23:0] mx, input logic signed [23:0] my);
		longint dx, dy, w, t, ww, ox, oy, nx, ny, sx, sy, ex, ey;
		int sgx, sgy;
		bit full, diag;
		logic signed [23:0] nbx, nby;
		logic [17:0] wbx, wby;
		dx = longint'(mx);
		dy = longint'(my);
		if (dx == 0 && dy == 0)
			return;
		w = (win_texels == 0) ? 1 : (win_texels > twsr_pkg::MAX_WINDOW
			? twsr_pkg::MAX_WINDOW : win_texels);
		t = (tex_size == 0) ? 1 : tex_size;
		ww = w * t;
		ox = longint'(base_x);
		oy = longint'(base_y);
		nx = ox + dx;
		ny = oy + dy;
		sgx = (dx > 0) - (dx < 0);
		sgy = (dy > 0) - (dy < 0);
		nbx = nx[23:0];
		nby = ny[23:0];
		wbx = 18'(fmod((longint'(nbx) - longint'(org_x)) / t, w) * t);
		wby = 18'(fmod((longint'(nby) - longint'(org_y)) / t, w) * t);
		full = dx > ww || -dx > ww || dy > ww || -dy > ww;
		diag = !full && dx != 0 && dy != 0;

		// first strip, or the whole window on a reload
		sx = nx; sy = ny; ex = nx + ww; ey = ny + ww;
		if (!full) begin
			if (sgx == 1 && sgy == 0) sx = ox + ww;
			else if (sgx == 1 && sgy == 1) begin sx = ox + ww; ey = oy + ww; end
			else if (sgx == 0 && sgy == 1) sy = oy + ww;
			else if (sgx == -1 && sgy == 1) begin ex = ox; ey = oy + ww; end
			else if (sgx == -1 && sgy == 0) ex = ox;
			else if (sgx == -1 && sgy == -1) begin sx = ox; ey = oy; end
			else if (sgx == 0 && sgy == -1) ey = oy;
			else begin ey = oy; ex = ox + ww; end
		end
		push_rect(0, sx, sy, ex, ey, w, wbx, wby, full, !diag);

		if (diag) begin
			// corner square
			ex = ox; ey = oy; sx = nx; sy = ny;
			if (sgx == 1 && sgy == 1) begin
				sx = ox + ww; sy = oy + ww; ex = nx + ww; ey = ny + ww;
			end else if (sgx == 1 && sgy == -1) begin
				sx = ox + ww; ex += ww;
			end else if (sgx == -1 && sgy == 1) begin
				sy = oy + ww; ey = ny + ww;
			end
			push_rect(1, sx, sy, ex, ey, w, wbx, wby, 1'b0, 1'b0);
			// second strip
			ex = ox; ey = oy; sx = nx; sy = ny;
			if (sgx == 1 && sgy == 1) begin
				sy = oy + ww; ex += ww; ey = ny + ww;
			end else if (sgx == 1 && sgy == -1) begin
				sx = ox + ww; ex = nx + ww; ey = ny + ww;
			end else if (sgx == -1 && sgy == 1) begin
				sy = oy + ww; ex = nx + ww; ey = ny + ww;
			end else begin
				sy = oy; ey = ny + ww;
			end
			push_rect(2, sx, sy, ex, ey, w, wbx, wby, 1'b0, 1'b1);
		end
		base_x = nbx;
		base_y = nby;
	endtask

	assign rects_pending = rect_q.size();

	always @(posedge clk or negedge arst_n) begin
		rect_t e;
		if (!arst_n) begin
			win_texels = 13'd256;
			tex_size   = 7'd1;
			org_x      = '0;
			org_y      = '0;
			base_x     = '0;
			base_y     = '0;
			fail_count = 0;
			rect_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					twsr_pkg::REG_WINDOW:   win_texels = cfg_data[12:0];
					twsr_pkg::REG_TEXEL:    tex_size   = cfg_data[6:0];
					twsr_pkg::REG_ORIGIN_X: org_x      = cfg_data;
					twsr_pkg::REG_ORIGIN_Y: org_y      = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_move(move_x, move_y);
			if (out_valid && !out_stall) begin
				if (rect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected rect beat: idx %0d start %0d,%0d",
							rect_index, start_x, start_y);
				end else begin
					e = rect_q.pop_front();
					if (e.idx !== rect_index || e.sx !== start_x || e.sy !== start_y ||
							e.ex !== end_x || e.ey !== end_y || e.wsx !== wrap_start_x ||
							e.wsy !== wrap_start_y || e.wbx !== wrap_base_x ||
							e.wby !== wrap_base_y || e.full !== full_reload ||
							e.fin !== last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("rect mismatch exp: idx %0d s %0d,%0d e %0d,%0d ws %0d,%0d wb %0d,%0d f %0d l %0d",
								e.idx, $signed(e.sx), $signed(e.sy), $signed(e.ex),
								$signed(e.ey), e.wsx, e.wsy, e.wbx, e.wby, e.full, e.fin);
							$display("rect mismatch got: idx %0d s %0d,%0d e %0d,%0d ws %0d,%0d wb %0d,%0d f %0d l %0d",
								rect_index, start_x, start_y, end_x, end_y, wrap_start_x,
								wrap_start_y, wrap_base_x, wrap_base_y, full_reload, last);
						end
					end
				end
			end
		end
	end

endmodule

### tb/toroidal_window_scroll_regions_tb.sv
`timescale 1ns / 1ps

module toroidal_window_scroll_regions_tb;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [23:0] move_x = '0;
	logic signed [23:0] move_y = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         rect_index;
	logic signed [23:0] start_x, start_y, end_x, end_y;
	logic [11:0]        wrap_start_x, wrap_start_y;
	logic [17:0]        wrap_base_x, wrap_base_y;
	logic               full_reload, last;
	int                 fail_count, rects_pending;

	// no idling on either side once this is set
	bit      quiet = 1'b0;
	int      stall_burst = 0;
	// window width in world units for the current setting, used to aim moves
	longint  span = 256;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	toroidal_window_scroll_regions uut (.*);

	twsr_scoreboard chk (.*);

	// receiver: random stall bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_burst > 0) begin
			stall_burst <= stall_burst - 1;
			out_stall   <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_burst <= $urandom_range(0, 4);
			out_stall   <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for all rects plus the divider tail, then load a new setting
	task automatic set_window(input logic [23:0] wt, input logic [23:0] ts,
			input logic [23:0] ox, input logic [23:0] oy);
		longint w, t;
		in_valid <= 1'b0;
		@(posedge clk);
		wait (rects_pending == 0);
		repeat (400) @(posedge clk);
		write_reg(twsr_pkg::REG_WINDOW, wt);
		write_reg(twsr_pkg::REG_TEXEL, ts);
		write_reg(twsr_pkg::REG_ORIGIN_X, ox);
		write_reg(twsr_pkg::REG_ORIGIN_Y, oy);
		w = (wt[12:0] == 0) ? 1 : (wt[12:0] > twsr_pkg::MAX_WINDOW
			? twsr_pkg::MAX_WINDOW : wt[12:0]);
		t = (ts[6:0] == 0) ? 1 : ts[6:0];
		span = w * t;
	endtask

	// one move beat; valid stays high into the next beat unless a gap follows
	task automatic send_move(input logic signed [23:0] mx, input logic signed [23:0] my);
		in_valid <= 1'b1;
		move_x   <= mx;
		move_y   <= my;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic logic signed [23:0] pick_axis();
		longint lim;
		int sel;
		lim = (span > 8388607) ? 8388607 : span;
		sel = $urandom_range(0, 19);
		if (sel < 3)
			return '0;
		else if (sel < 5)
			return 24'($urandom);
		else if (sel < 7)
			return ($urandom_range(0, 1) ? 24'sd1 : -24'sd1) * 24'(lim + 1 + $urandom_range(0, 99));
		else if (sel < 8)
			return $urandom_range(0, 1) ? 24'(lim) : -24'(lim);
		else
			return 24'($urandom_range(0, 2 * lim) - lim);
	endfunction

	task automatic random_moves(input int n);
		for (int i = 0; i < n; i++)
			send_move(pick_axis(), pick_axis());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zero, all eight sign cases, edges of the window, reloads
		send_move(0, 0);
		send_move(5, 0);
		send_move(7, 9);
		send_move(0, 3);
		send_move(-4, 6);
		send_move(-8, 0);
		send_move(-2, -3);
		send_move(0, -11);
		send_move(13, -6);
		send_move(256, 256);
		send_move(-256, -256);
		send_move(257, 0);
		send_move(0, -257);
		send_move(24'sh7fffff, 24'sh7fffff);
		send_move(-24'sh800000, -24'sh800000);
		send_move(24'sh7fffff, -24'sh800000);
		send_move(1, 1);
		random_moves(40);

		// hold off until every rect of the backlog has drained
		in_valid <= 1'b0;
		@(posedge clk);
		wait (rects_pending == 0);
		random_moves(20);

		set_window(24'd16, 24'd3, 24'($urandom), 24'($urandom));
		random_moves(80);
		set_window(24'd1, 24'd1, 24'h000005, 24'hfffffb);
		random_moves(60);
		// zero sizes act as one
		set_window(24'hffe000, 24'hffff80, 24'h7fffff, 24'h800000);
		random_moves(60);
		// oversized window saturates, largest texel
		set_window(24'h001fff, 24'h00007f, 24'h800000, 24'h7fffff);
		send_move(24'sh7fffff, 24'sh7fffff);
		send_move(-24'sh800000, -24'sh800000);
		random_moves(60);
		set_window(24'd4096, 24'd64, 24'($urandom), 24'($urandom));
		random_moves(60);
		set_window(24'd100, 24'd7, 24'($urandom), 24'($urandom));
		random_moves(30);
		quiet = 1'b1;
		random_moves(40);
		in_valid <= 1'b0;

		@(posedge clk);
		wait (rects_pending == 0);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && rects_pending == 0)
			$display("toroidal_window_scroll_regions_tb: PASS");
		else
			$display("toroidal_window_scroll_regions_tb: FAIL");
		$finish;
	end

	initial begin
		#10ms;
		$display("toroidal_window_scroll_regions_tb: FAIL");
		$finish;
	end

endmodule
